@@ src/irm_pkg.sv @@
`timescale 1ns / 1ps

package irm_pkg;

  // Packet length limit: bytes at or beyond this position are ignored.
  localparam int MaxPacket = 1024;

  // Byte position counter width; the counter saturates at its all-ones value.
  localparam int PosW = 11;
  localparam logic [PosW-1:0] PosMax = '1;

  // Width that holds a packet length up to the saturated position plus one.
  localparam int LenW = 17;

  // ICMP message types.
  localparam logic [7:0] TypeEchoReply    = 8'd0;
  localparam logic [7:0] TypeTimeExceeded = 8'd11;

  // Header length field is counted in 32-bit words.
  localparam int HdrLenW = 6;

  // Configuration register indexes.
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CfgExpectedId  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgExpectedSeq = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSendTime    = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgDestAddr    = 2'd3;

  // Result status codes.
  localparam logic [1:0] StatusAccepted  = 2'd0;
  localparam logic [1:0] StatusTooShort  = 2'd1;
  localparam logic [1:0] StatusOtherType = 2'd2;
  localparam logic [1:0] StatusMismatch  = 2'd3;

  typedef struct packed {
    logic [15:0] expected_id;
    logic [15:0] expected_sequence;
    logic [31:0] send_time;
    logic [31:0] destination_address;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] arrival_time;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        message_kind;
    logic [31:0] source_address;
    logic [31:0] round_trip_ms;
    logic        reached_destination;
  } result_t;

endpackage

@@ src/irm_channels.sv @@
`timescale 1ns / 1ps

// Packet byte channel.
interface irm_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [31:0] arrival_time;

  modport source (output valid, output data_byte, output last_byte, output arrival_time,
                  input ready);
  modport sink (input valid, input data_byte, input last_byte, input arrival_time,
                output ready);
endinterface

// Match result channel.
interface irm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        message_kind;
  logic [31:0] source_address;
  logic [31:0] round_trip_ms;
  logic        reached_destination;

  modport source (output valid, output status, output message_kind, output source_address,
                  output round_trip_ms, output reached_destination, input ready);
  modport sink (input valid, input status, input message_kind, input source_address,
                input round_trip_ms, input reached_destination, output ready);
endinterface

@@ src/icmp_reply_matcher.sv @@
`timescale 1ns / 1ps

// ICMP reply matcher: takes one received IPv4 packet byte per item, starting at
// the IP header, and gives one result on the byte marked last. It accepts one byte
// every clock cycle; the only thing that holds input back is a finished result that
// sits unclaimed in the output register while the next packet's last byte arrives.
// A byte goes through an input register and then a single step of compare-and-
// capture logic, whose result is registered in the output register when the last
// byte moves on. Configuration writes take effect on the next cycle and must be made
// while no packet is in flight.
module icmp_reply_matcher (
  input  logic                          clk,
  input  logic                          rst,
  irm_in_if.sink                        packet,
  irm_out_if.source                     reply,
  input  logic                          cfg_write,
  input  logic [irm_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [irm_pkg::CfgDataW-1:0]  cfg_data
);
  import irm_pkg::*;

  cfg_t    cfg;
  item_t   stage_item;
  result_t result;
  logic    stage_valid;
  logic    step;
  logic    out_free;
  logic    out_load;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CfgExpectedId:  cfg.expected_id         <= cfg_data[15:0];
        CfgExpectedSeq: cfg.expected_sequence   <= cfg_data[15:0];
        CfgSendTime:    cfg.send_time           <= cfg_data;
        CfgDestAddr:    cfg.destination_address <= cfg_data;
        default: ;
      endcase
    end
  end

  // A byte moves on unless it ends a packet and the result register is full.
  assign step     = stage_valid && (!stage_item.last_byte || out_free);
  assign out_load = step && stage_item.last_byte;

  irm_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .packet      (packet),
    .step        (step),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  irm_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (stage_item),
    .cfg    (cfg),
    .result (result)
  );

  irm_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (out_load),
    .result (result),
    .free   (out_free),
    .reply  (reply)
  );

  // A last byte that moves on always shows up as a result.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    out_load |=> reply.valid)
    else $error("last byte produced no result");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !reply.valid || reply.ready)
    else $error("result register overwritten");

  // Only an accepted reply can report the destination as reached.
  a_reached_accepted: assert property (@(posedge clk) disable iff (rst)
    reply.valid && reply.reached_destination |->
      reply.status == StatusAccepted && reply.source_address == cfg.destination_address)
    else $error("destination reached on a rejected reply");

endmodule

@@ src/irm_in_reg.sv @@
`timescale 1ns / 1ps

module irm_in_reg (
  input  logic           clk,
  input  logic           rst,
  irm_in_if.sink         packet,
  input  logic           step,
  output logic           stage_valid,
  output irm_pkg::item_t stage_item
);
  import irm_pkg::*;

  logic load;

  // The stage takes a new item when empty or when its current item moves on.
  assign packet.ready = !stage_valid || step;
  assign load = packet.valid && packet.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (load) begin
      stage_valid <= 1'b1;
    end else if (step) begin
      stage_valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      stage_item.data_byte    <= packet.data_byte;
      stage_item.last_byte    <= packet.last_byte;
      stage_item.arrival_time <= packet.arrival_time;
    end
  end

endmodule

@@ src/irm_parser.sv @@
`timescale 1ns / 1ps

module irm_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  irm_pkg::item_t   item,
  input  irm_pkg::cfg_t    cfg,
  output irm_pkg::result_t result
);
  import irm_pkg::*;

  // Per-packet state.
  logic [PosW-1:0]    byte_position;
  logic [HdrLenW-1:0] outer_header_bytes;
  logic [HdrLenW-1:0] inner_header_bytes;
  logic [7:0]         message_type;
  logic [15:0]        captured_id;
  logic [15:0]        captured_sequence;
  logic [31:0]        captured_source;
  logic               fields_seen;

  logic [PosW-1:0]    byte_position_next;
  logic [HdrLenW-1:0] outer_header_bytes_next;
  logic [HdrLenW-1:0] inner_header_bytes_next;
  logic [7:0]         message_type_next;
  logic [15:0]        captured_id_next;
  logic [15:0]        captured_sequence_next;
  logic [31:0]        captured_source_next;
  logic               fields_seen_next;

  logic               start;
  logic               in_window;
  logic               cap_en;
  logic [7:0]         cap_base;
  logic [PosW-1:0]    cap_pos;
  logic [7:0]         b;
  logic [LenW-1:0]    len_raw;
  logic [LenW-1:0]    length;
  logic               too_short;
  logic               is_echo;
  logic               is_te;

  assign b = item.data_byte;

  // Field capture for the current byte.
  always_comb begin
    start     = (byte_position == '0);
    in_window = (LenW'(byte_position) < LenW'(MaxPacket));

    // Every capture starts clean on the first byte of a packet.
    outer_header_bytes_next = start ? '0 : outer_header_bytes;
    inner_header_bytes_next = start ? '0 : inner_header_bytes;
    message_type_next       = start ? '0 : message_type;
    captured_id_next        = start ? '0 : captured_id;
    captured_sequence_next  = start ? '0 : captured_sequence;
    captured_source_next    = start ? '0 : captured_source;
    fields_seen_next        = start ? 1'b0 : fields_seen;

    if (in_window && start) begin
      outer_header_bytes_next = {b[3:0], 2'b00};
    end
    if (in_window && byte_position >= PosW'(12) && byte_position <= PosW'(15)) begin
      captured_source_next = {captured_source_next[23:0], b};
    end
    if (in_window && byte_position == PosW'(outer_header_bytes_next)) begin
      message_type_next = b;
    end

    is_echo = (message_type_next == TypeEchoReply);
    is_te   = (message_type_next == TypeTimeExceeded);

    // Inner IP header length sits eight bytes past the ICMP type.
    if (in_window && is_te &&
        byte_position == PosW'(outer_header_bytes_next) + PosW'(8)) begin
      inner_header_bytes_next = {b[3:0], 2'b00};
    end

    // ID and sequence come from the outer ICMP header or the quoted one.
    cap_base = is_te ? 8'(outer_header_bytes_next) + 8'd8 + 8'(inner_header_bytes_next)
                     : 8'(outer_header_bytes_next);
    cap_pos  = PosW'(cap_base);
    cap_en   = in_window && (is_echo || is_te);
    if (cap_en && byte_position == cap_pos + PosW'(4)) begin
      captured_id_next[15:8] = b;
    end
    if (cap_en && byte_position == cap_pos + PosW'(5)) begin
      captured_id_next[7:0] = b;
    end
    if (cap_en && byte_position == cap_pos + PosW'(6)) begin
      captured_sequence_next[15:8] = b;
    end
    if (cap_en && byte_position == cap_pos + PosW'(7)) begin
      captured_sequence_next[7:0] = b;
      fields_seen_next = 1'b1;
    end

    // Position wraps to zero after the last byte and saturates otherwise.
    if (item.last_byte) begin
      byte_position_next = '0;
    end else if (byte_position != PosMax) begin
      byte_position_next = byte_position + PosW'(1);
    end else begin
      byte_position_next = byte_position;
    end
  end

  // Verdict for a packet ending on this byte.
  always_comb begin
    len_raw   = LenW'(byte_position) + LenW'(1);
    length    = (len_raw > LenW'(MaxPacket)) ? LenW'(MaxPacket) : len_raw;
    too_short = (length < LenW'(outer_header_bytes_next) + LenW'(8));

    priority if (too_short) begin
      result.status = StatusTooShort;
    end else if (!is_echo && !is_te) begin
      result.status = StatusOtherType;
    end else if (!fields_seen_next) begin
      result.status = StatusTooShort;
    end else if (captured_id_next != cfg.expected_id ||
                 captured_sequence_next != cfg.expected_sequence) begin
      result.status = StatusMismatch;
    end else begin
      result.status = StatusAccepted;
    end

    result.message_kind        = is_te;
    result.source_address      = captured_source_next;
    result.round_trip_ms       = item.arrival_time - cfg.send_time;
    result.reached_destination = (result.status == StatusAccepted) &&
                                 (captured_source_next == cfg.destination_address);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      outer_header_bytes <= '0;
      inner_header_bytes <= '0;
      message_type       <= '0;
      captured_id        <= '0;
      captured_sequence  <= '0;
      captured_source    <= '0;
      fields_seen        <= 1'b0;
    end else if (step) begin
      byte_position      <= byte_position_next;
      outer_header_bytes <= outer_header_bytes_next;
      inner_header_bytes <= inner_header_bytes_next;
      message_type       <= message_type_next;
      captured_id        <= captured_id_next;
      captured_sequence  <= captured_sequence_next;
      captured_source    <= captured_source_next;
      fields_seen        <= fields_seen_next;
    end
  end

  // A new packet always starts at position zero.
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    step && item.last_byte |=> byte_position == '0)
    else $error("byte position not cleared after last byte");

  // Fields are only marked seen for the two supported message types.
  a_seen_type: assert property (@(posedge clk) disable iff (rst)
    fields_seen && byte_position != '0 |->
      message_type == TypeEchoReply || message_type == TypeTimeExceeded)
    else $error("fields seen for an unsupported message type");

endmodule

@@ src/irm_out_reg.sv @@
`timescale 1ns / 1ps

module irm_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  irm_pkg::result_t result,
  output logic             free,
  irm_out_if.source        reply
);
  import irm_pkg::*;

  result_t held;

  // The register can take a result when empty or being drained this cycle.
  assign free = !reply.valid || reply.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      reply.valid <= 1'b0;
    end else if (load) begin
      reply.valid <= 1'b1;
    end else if (reply.ready) begin
      reply.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign reply.status              = held.status;
  assign reply.message_kind        = held.message_kind;
  assign reply.source_address      = held.source_address;
  assign reply.round_trip_ms       = held.round_trip_ms;
  assign reply.reached_destination = held.reached_destination;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import irm_pkg::*;

  localparam int StallLimit      = 2000;
  localparam int ReplyHoldCycles = 300;
  localparam int DrainCycles     = 8;
  localparam int PhaseBytes      = 175;
  localparam int PhaseFrames     = 12;

  // One row of the directed table: a packet byte and, where it is obvious, its result.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] arrival_time;
    logic        typed;
    result_t     want;
  } stim_row_t;

  localparam result_t NoWant = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  irm_in_if  packet_ch ();
  irm_out_if reply_ch ();

  icmp_reply_matcher dut (
    .clk       (clk),
    .rst       (rst),
    .packet    (packet_ch),
    .reply     (reply_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Register copies as the matcher should hold them.
  logic [15:0] want_id    = '0;
  logic [15:0] want_seq   = '0;
  logic [31:0] sent_at    = '0;
  logic [31:0] probe_addr = '0;

  // Parser state of the matcher.
  logic [PosW-1:0]    frame_pos  = '0;
  logic [HdrLenW-1:0] outer_len  = '0;
  logic [HdrLenW-1:0] inner_len  = '0;
  logic [7:0]         msg_type   = '0;
  logic [15:0]        cap_id     = '0;
  logic [15:0]        cap_seq    = '0;
  logic [31:0]        cap_src    = '0;
  logic               tag_done   = 1'b0;

  result_t     awaited_replies [$];
  logic [7:0]  frame_bytes [$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  bit          hold_reply = 1'b0;

  // Directed packets, sent right after reset with every register at zero.
  stim_row_t directed_rows [29] = '{
    // A one-byte packet is too short; the round trip is all ones.
    '{8'h00, 1'b1, 32'hFFFF_FFFF, 1'b1,
      '{StatusTooShort, 1'b0, 32'h0, 32'hFFFF_FFFF, 1'b0}},
    // Echo reply with a zero header length: the type byte is byte 0 itself.
    '{8'h00, 1'b0, 32'h0, 1'b0, NoWant},
    '{8'h00, 1'b0, 32'h0, 1'b0, NoWant},
    '{8'h00, 1'b0, 32'h0, 1'b0, NoWant},
    '{8'h00, 1'b0, 32'h0, 1'b0, NoWant},
    '{8'h00, 1'b0, 32'h0, 1'b0, NoWant},
    '{8'h00, 1'b0, 32'h0, 1'b0, NoWant},
    '{8'h00, 1'b0, 32'h0, 1'b0, NoWant},
    '{8'h00, 1'b1, 32'h0, 1'b1,
      '{StatusAccepted, 1'b0, 32'h0, 32'h0, 1'b1}},
    // Type 0xF0 at a zero header length is some other message type.
    '{8'hF0, 1'b0, 32'h0, 1'b0, NoWant},
    '{8'hFF, 1'b0, 32'h0, 1'b0, NoWant},
    '{8'hFF, 1'b0, 32'h0, 1'b0, NoWant},
    '{8'hFF, 1'b0, 32'h0, 1'b0, NoWant},
    '{8'hFF, 1'b0, 32'h0, 1'b0, NoWant},
    '{8'hFF, 1'b0, 32'h0, 1'b0, NoWant},
    '{8'hFF, 1'b0, 32'h0, 1'b0, NoWant},
    '{8'hFF, 1'b1, 32'h8000_0000, 1'b1,
      '{StatusOtherType, 1'b0, 32'h0, 32'h8000_0000, 1'b0}},
    // Time exceeded that ends before the quoted ICMP header.
    '{8'h01, 1'b0, 32'h0, 1'b0, NoWant},
    '{8'hA5, 1'b0, 32'h0, 1'b0, NoWant},
    '{8'h5A, 1'b0, 32'h0, 1'b0, NoWant},
    '{8'hA5, 1'b0, 32'h0, 1'b0, NoWant},
    '{TypeTimeExceeded, 1'b0, 32'h0, 1'b0, NoWant},
    '{8'h5A, 1'b0, 32'h0, 1'b0, NoWant},
    '{8'hA5, 1'b0, 32'h0, 1'b0, NoWant},
    '{8'h5A, 1'b0, 32'h0, 1'b0, NoWant},
    '{8'hA5, 1'b0, 32'h0, 1'b0, NoWant},
    '{8'h5A, 1'b0, 32'h0, 1'b0, NoWant},
    '{8'hA5, 1'b0, 32'h0, 1'b0, NoWant},
    '{8'h5A, 1'b1, 32'h7FFF_FFFF, 1'b1,
      '{StatusTooShort, 1'b1, 32'h0, 32'h7FFF_FFFF, 1'b0}}
  };

  // Captures the ID and sequence bytes that sit at a given header base.
  function automatic void take_tag(input int p, input int base, input logic [7:0] b);
    if (p == base + 4) cap_id[15:8] = b;
    if (p == base + 5) cap_id[7:0] = b;
    if (p == base + 6) cap_seq[15:8] = b;
    if (p == base + 7) begin
      cap_seq[7:0] = b;
      tag_done = 1'b1;
    end
  endfunction

  // Advances the parser by one packet byte; returns 1 with the result on a last byte.
  function automatic bit match_byte(input logic [7:0] b, input logic lst,
                                    input logic [31:0] tick, output result_t r);
    int p;
    int len;
    p = frame_pos;
    r = '0;
    if (p == 0) begin
      outer_len = '0;
      inner_len = '0;
      msg_type  = '0;
      cap_id    = '0;
      cap_seq   = '0;
      cap_src   = '0;
      tag_done  = 1'b0;
    end

    // Bytes past the packet limit are ignored.
    if (p < MaxPacket) begin
      if (p == 0) outer_len = {b[3:0], 2'b00};
      if (p >= 12 && p <= 15) cap_src = {cap_src[23:0], b};
      if (p == outer_len) msg_type = b;
      if (msg_type == TypeEchoReply) begin
        take_tag(p, outer_len, b);
      end else if (msg_type == TypeTimeExceeded) begin
        if (p == outer_len + 8) inner_len = {b[3:0], 2'b00};
        take_tag(p, outer_len + 8 + inner_len, b);
      end
    end

    if (!lst) begin
      if (frame_pos != PosMax) frame_pos = frame_pos + 1'b1;
      return 1'b0;
    end

    len = p + 1;
    if (len > MaxPacket) len = MaxPacket;
    if (len < outer_len + 8) r.status = StatusTooShort;
    else if (msg_type != TypeEchoReply && msg_type != TypeTimeExceeded)
      r.status = StatusOtherType;
    else if (!tag_done) r.status = StatusTooShort;
    else if (cap_id != want_id || cap_seq != want_seq) r.status = StatusMismatch;
    else r.status = StatusAccepted;
    r.message_kind = (msg_type == TypeTimeExceeded);
    r.source_address = cap_src;
    r.round_trip_ms = tick - sent_at;
    r.reached_destination = (r.status == StatusAccepted) && (cap_src == probe_addr);
    frame_pos = '0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("[%0t] reply %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Mostly back to back, sometimes a short pause, rarely a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one packet byte, waits until it is taken and records its expected result.
  task automatic push_byte(input logic [7:0] b, input logic lst, input logic [31:0] tick,
                           input int gap, input logic typed, input result_t want);
    result_t predicted;
    @(negedge clk);
    if (gap > 0) begin
      packet_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    packet_ch.valid        <= 1'b1;
    packet_ch.data_byte    <= b;
    packet_ch.last_byte    <= lst;
    packet_ch.arrival_time <= tick;
    @(posedge clk);
    while (!packet_ch.ready) @(posedge clk);
    if (match_byte(b, lst, tick, predicted))
      awaited_replies.push_back(typed ? want : predicted);
  endtask

  function automatic void put(input int idx, input logic [7:0] v);
    if (idx < frame_bytes.size()) frame_bytes[idx] = v;
  endfunction

  // Builds a random packet: mostly echo replies and time exceeded messages with
  // random content, some other types, some truncated, some plain noise.
  task automatic build_frame(input int stretch);
    int pick;
    int ihl;
    int inner;
    int o;
    int base;
    int len;
    int tag_at;
    int roll;
    logic [7:0]  kind_byte;
    logic [15:0] id_v;
    logic [15:0] seq_v;
    pick  = $urandom_range(0, 99);
    ihl   = $urandom_range(0, 1) ? 5 : $urandom_range(0, 15);
    inner = ($urandom_range(0, 2) != 0) ? 5 : $urandom_range(0, 15);
    o     = 4 * ihl;
    base  = o + 8 + 4 * inner;
    if (pick < 45) len = o + 8 + $urandom_range(0, 6);
    else if (pick < 75) len = base + 8 + $urandom_range(0, 6);
    else if (pick < 85) len = o + 8 + $urandom_range(0, 6);
    else len = $urandom_range(1, 12);
    if (pick < 75 && $urandom_range(0, 9) == 0) len = $urandom_range(1, len - 1);
    len += stretch;

    frame_bytes.delete();
    repeat (len) frame_bytes.push_back(8'($urandom));
    if (pick >= 85) return;

    // Source address usually equals the probed host.
    if ($urandom_range(0, 2) != 0)
      for (int k = 0; k < 4; k++) put(12 + k, probe_addr[31 - 8 * k -: 8]);
    put(0, {4'($urandom), 4'(ihl)});
    if (pick < 45) kind_byte = TypeEchoReply;
    else if (pick < 75) kind_byte = TypeTimeExceeded;
    else begin
      kind_byte = 8'($urandom);
      while (kind_byte == TypeEchoReply || kind_byte == TypeTimeExceeded)
        kind_byte = 8'($urandom);
    end
    put(o, kind_byte);
    if (pick >= 75) return;

    if (pick >= 45) put(o + 8, {4'h4, 4'(inner)});
    tag_at = (pick < 45) ? o + 4 : base + 4;
    id_v  = want_id;
    seq_v = want_seq;
    roll  = $urandom_range(0, 9);
    if (roll >= 8) seq_v = 16'($urandom);
    else if (roll >= 6) id_v = id_v ^ (16'd1 << $urandom_range(0, 15));
    put(tag_at,     id_v[15:8]);
    put(tag_at + 1, id_v[7:0]);
    put(tag_at + 2, seq_v[15:8]);
    put(tag_at + 3, seq_v[7:0]);
  endtask

  // Sends the built packet, either as one burst or with random pauses.
  task automatic send_frame();
    bit burst;
    burst = ($urandom_range(0, 3) == 0);
    foreach (frame_bytes[i])
      push_byte(frame_bytes[i], i == frame_bytes.size() - 1, $urandom,
                burst ? 0 : pick_gap(), 1'b0, NoWant);
  endtask

  // Lets the matcher go idle: nothing offered, every result collected.
  task automatic drain_matcher();
    @(negedge clk);
    packet_ch.valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Writes all four registers on consecutive cycles.
  task automatic program_registers(input logic [15:0] id, input logic [15:0] seq,
                                   input logic [31:0] tsend, input logic [31:0] dest);
    logic [CfgDataW-1:0] value [4];
    logic [CfgIdxW-1:0]  reg_index [4];
    value[0] = {16'($urandom), id};
    value[1] = {16'($urandom), seq};
    value[2] = tsend;
    value[3] = dest;
    reg_index[0] = CfgExpectedId;
    reg_index[1] = CfgExpectedSeq;
    reg_index[2] = CfgSendTime;
    reg_index[3] = CfgDestAddr;
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= reg_index[i];
      cfg_data  <= value[i];
    end
    @(negedge clk);
    cfg_write <= 1'b0;
    want_id    = value[0][15:0];
    want_seq   = value[1][15:0];
    sent_at    = value[2];
    probe_addr = value[3];
  endtask

  // Result side: random ready pattern, plus one long hold-off on request.
  initial begin : reply_pacing
    int roll;
    int span;
    logic level;
    reply_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      if (hold_reply) begin
        level = 1'b0;
        span = ReplyHoldCycles;
        hold_reply = 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          level = 1'b1;
          span = $urandom_range(1, 8);
        end else if (roll < 75) begin
          level = 1'b1;
          span = $urandom_range(16, 64);
        end else if (roll < 93) begin
          level = 1'b0;
          span = $urandom_range(1, 3);
        end else begin
          level = 1'b0;
          span = $urandom_range(10, 60);
        end
      end
      @(negedge clk);
      reply_ch.ready <= level;
      repeat (span - 1) @(negedge clk);
    end
  end

  // Compares each result item taken with the oldest expectation.
  always @(posedge clk) begin : check_replies
    result_t seen;
    result_t want;
    if (!rst && reply_ch.valid && reply_ch.ready) begin
      seen.status              = reply_ch.status;
      seen.message_kind        = reply_ch.message_kind;
      seen.source_address      = reply_ch.source_address;
      seen.round_trip_ms       = reply_ch.round_trip_ms;
      seen.reached_destination = reply_ch.reached_destination;
      if (awaited_replies.size() == 0) begin
        report_mismatch("with none pending, source", seen.source_address, 32'h0);
      end else begin
        want = awaited_replies.pop_front();
        if (seen.status !== want.status)
          report_mismatch("status", seen.status, want.status);
        if (seen.message_kind !== want.message_kind)
          report_mismatch("message_kind", seen.message_kind, want.message_kind);
        if (seen.source_address !== want.source_address)
          report_mismatch("source_address", seen.source_address, want.source_address);
        if (seen.round_trip_ms !== want.round_trip_ms)
          report_mismatch("round_trip_ms", seen.round_trip_ms, want.round_trip_ms);
        if (seen.reached_destination !== want.reached_destination)
          report_mismatch("reached_destination", seen.reached_destination,
                          want.reached_destination);
      end
    end
  end

  // Ends the run when neither side has moved an item for too long.
  always @(posedge clk) begin
    if (rst || (packet_ch.valid && packet_ch.ready) || (reply_ch.valid && reply_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : main_flow
    int phase_bytes;
    int phase_frames;
    packet_ch.valid        = 1'b0;
    packet_ch.data_byte    = '0;
    packet_ch.last_byte    = 1'b0;
    packet_ch.arrival_time = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed table with the registers at their reset values.
    foreach (directed_rows[i])
      push_byte(directed_rows[i].data_byte, directed_rows[i].last_byte,
                directed_rows[i].arrival_time, pick_gap(), directed_rows[i].typed,
                directed_rows[i].want);

    // Random phases: all ones, random, all zeros, random.
    for (int ph = 0; ph < 4; ph++) begin
      drain_matcher();
      case (ph)
        0: program_registers(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: program_registers(16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000);
        default: program_registers(16'($urandom), 16'($urandom), $urandom, $urandom);
      endcase
      // The result side holds off for a long stretch so the input backs up.
      if (ph == 1) hold_reply = 1'b1;
      phase_bytes = 0;
      phase_frames = 0;
      while (phase_bytes < PhaseBytes || phase_frames < PhaseFrames) begin
        build_frame(0);
        send_frame();
        phase_bytes += frame_bytes.size();
        phase_frames++;
      end
      // Packets past the length limit, one long enough to saturate the position.
      if (ph == 3) begin
        build_frame(MaxPacket + $urandom_range(0, 8));
        send_frame();
        build_frame(2 * MaxPacket + $urandom_range(0, 60));
        send_frame();
      end
    end

    drain_matcher();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
